FILE: rtl/core/base64_decoder_assert.svh
// ----------------------------------------------------------------------------
// Base64 decoder assertion macros
// Shared property wrappers for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define B64D_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("b64d invariant violated");

// Condition in one cycle implies the other in the next cycle.
`define B64D_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("b64d sequence violated");

`endif

FILE: rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Types, character constants and the alphabet lookup shared by the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int B64D_RSP_DEPTH = 8;
   localparam int MAX_RESULTS    = 3;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   localparam logic [7:0] LOWER_BASE  = 8'd26;
   localparam logic [7:0] DIGIT_BASE  = 8'd52;
   localparam logic [5:0] PLUS_VALUE  = 6'd62;
   localparam logic [5:0] SLASH_VALUE = 6'd63;

   // quartet flag bit positions
   localparam int FLAG_BAD  = 0;
   localparam int FLAG_PAD0 = 1;
   localparam int FLAG_PAD1 = 2;
   localparam int FLAG_PAD2 = 3;

   localparam logic [1:0] LAST_POS = 2'd3;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_LENGTH    = 2'd1,
      ST_BAD_CHAR  = 2'd2,
      ST_EARLY_PAD = 2'd3
   } status_type;

   typedef struct packed {
      logic [5:0] value;
      logic       pad;
      logic       bad;
   } sextet_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_done;
      status_type status;
   } result_type;

   // up to three results caused by one character, item[0] first
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] item;
   } bundle_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r.value = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r.value = 6'(c - CHAR_LOWER_A + LOWER_BASE);
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         r.value = 6'(c - CHAR_DIGIT_0 + DIGIT_BASE);
      end else if (c == CHAR_PLUS) begin
         r.value = PLUS_VALUE;
      end else if (c == CHAR_SLASH) begin
         r.value = SLASH_VALUE;
      end else if (c == CHAR_PAD) begin
         r.pad = 1'b1;
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/b64d_req_if.sv
// ----------------------------------------------------------------------------
// Base64 decoder request channel
// Valid/ready channel carrying one input character per word.
// ----------------------------------------------------------------------------
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_message;

   modport source (output valid, output char_code, output end_of_message, input ready);
   modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

FILE: rtl/core/b64d_rsp_if.sv
// ----------------------------------------------------------------------------
// Base64 decoder response channel
// Valid/ready channel carrying one decoded result per word.
// ----------------------------------------------------------------------------
interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       message_done;
   logic [1:0] status;

   modport source (output valid, output data_byte, output byte_valid,
                   output message_done, output status, input ready);
   modport sink   (input valid, input data_byte, input byte_valid,
                   input message_done, input status, output ready);
endinterface

FILE: rtl/core/b64d_quartet.sv
// ----------------------------------------------------------------------------
// Base64 quartet engine
// Gathers sextets, judges each quartet and forms its result words.
// ----------------------------------------------------------------------------
`include "base64_decoder_assert.svh"

module b64d_quartet
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_code,
   input  logic       end_of_message,
   output bundle_type bundle
);

   logic [1:0] pos_ff, pos_in;
   logic [3:0] flags_ff, flags_in;
   logic       stopped_ff, stopped_in;
   status_type status_ff, status_in;
   logic [5:0] held_ff [3];
   logic       held_we;

   sextet_type sx;
   logic [3:0] flags_now;
   logic       err;
   status_type err_status;
   logic       clear;
   logic [1:0] nbytes;
   logic [7:0] byte0, byte1, byte2;

   assign sx        = sextet_of(char_code);
   assign flags_now = flags_ff | {3'b000, sx.bad};
   assign byte0     = {held_ff[0], held_ff[1][5:4]};
   assign byte1     = {held_ff[1][3:0], held_ff[2][5:2]};
   assign byte2     = {held_ff[2][1:0], sx.value};

   always_comb begin
      err        = 1'b0;
      err_status = ST_OK;
      if (flags_now[FLAG_BAD]) begin
         err        = 1'b1;
         err_status = ST_BAD_CHAR;
      end else if (flags_now[FLAG_PAD0] || flags_now[FLAG_PAD1]) begin
         err        = 1'b1;
         err_status = ST_EARLY_PAD;
      end
   end

   always_comb begin
      bundle     = '0;
      pos_in     = pos_ff;
      flags_in   = flags_ff;
      stopped_in = stopped_ff;
      status_in  = status_ff;
      held_we    = 1'b0;
      clear      = 1'b0;
      nbytes     = 2'd0;
      if (step) begin
         if (stopped_ff) begin
            // ignore the rest of the message, report on its last character
            if (end_of_message) begin
               bundle.count                = 2'd1;
               bundle.item[0].message_done = 1'b1;
               bundle.item[0].status       = status_ff;
               clear                       = 1'b1;
            end
         end else if (pos_ff != LAST_POS) begin
            held_we  = 1'b1;
            flags_in = flags_now | (4'(sx.pad) << (3'(pos_ff) + 3'(FLAG_PAD0)));
            pos_in   = pos_ff + 2'd1;
            if (end_of_message) begin
               bundle.count                = 2'd1;
               bundle.item[0].message_done = 1'b1;
               bundle.item[0].status       = ST_LENGTH;
               clear                       = 1'b1;
            end
         end else begin
            pos_in   = 2'd0;
            flags_in = '0;
            if (err) begin
               stopped_in = 1'b1;
               status_in  = err_status;
               if (end_of_message) begin
                  bundle.count                = 2'd1;
                  bundle.item[0].message_done = 1'b1;
                  bundle.item[0].status       = err_status;
                  clear                       = 1'b1;
               end
            end else begin
               status_in = ST_OK;
               if (flags_now[FLAG_PAD2]) begin
                  nbytes     = 2'd1;
                  stopped_in = 1'b1;
               end else if (sx.pad) begin
                  nbytes     = 2'd2;
                  stopped_in = 1'b1;
               end else begin
                  nbytes = 2'd3;
               end
               bundle.count = nbytes;
               bundle.item[0].data_byte  = byte0;
               bundle.item[0].byte_valid = 1'b1;
               bundle.item[1].data_byte  = byte1;
               bundle.item[1].byte_valid = 1'b1;
               bundle.item[2].data_byte  = byte2;
               bundle.item[2].byte_valid = 1'b1;
               // done rides on the last byte of the quartet
               case (nbytes)
                  2'd1:    bundle.item[0].message_done = end_of_message;
                  2'd2:    bundle.item[1].message_done = end_of_message;
                  default: bundle.item[2].message_done = end_of_message;
               endcase
               // drop bytes beyond the count
               if (nbytes < 2'd3) begin
                  bundle.item[2] = '0;
               end
               if (nbytes < 2'd2) begin
                  bundle.item[1] = '0;
               end
               clear = end_of_message;
            end
         end
      end
      if (clear) begin
         pos_in     = 2'd0;
         flags_in   = '0;
         stopped_in = 1'b0;
         status_in  = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 2'd0;
         flags_ff   <= '0;
         stopped_ff <= 1'b0;
         status_ff  <= ST_OK;
      end else begin
         pos_ff     <= pos_in;
         flags_ff   <= flags_in;
         stopped_ff <= stopped_in;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_we && !sx.pad) begin
         held_ff[pos_ff] <= sx.value;
      end else if (held_we) begin
         held_ff[pos_ff] <= '0;
      end
   end

   `B64D_ASSERT_ALWAYS(a_stop_aligned, clock, reset, !stopped_ff || pos_ff == 2'd0)
   `B64D_ASSERT_ALWAYS(a_status_quiet, clock, reset, stopped_ff || status_ff == ST_OK)
   `B64D_ASSERT_NEXT(a_eom_clears, clock, reset, step && end_of_message,
      pos_ff == 2'd0 && !stopped_ff && flags_ff == 4'd0)

endmodule

FILE: rtl/core/b64d_rsp_fifo.sv
// ----------------------------------------------------------------------------
// Base64 decoder result queue
// Takes up to three result words a cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
`include "base64_decoder_assert.svh"

module b64d_rsp_fifo
   import b64d_pkg::*;
#(
   parameter int DEPTH = B64D_RSP_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  bundle_type push,
   output logic       room,
   b64d_rsp_if.source rsp_bus
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0] ROOM_LIMIT = (AW+1)'(DEPTH - MAX_RESULTS);

   result_type      mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            pop;
   result_type      head;

   assign room = count_ff <= ROOM_LIMIT;
   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign head = mem[rd_ptr_ff];

   assign rsp_bus.valid        = count_ff != '0;
   assign rsp_bus.data_byte    = head.data_byte;
   assign rsp_bus.byte_valid   = head.byte_valid;
   assign rsp_bus.message_done = head.message_done;
   assign rsp_bus.status       = head.status;

   assign wr_ptr_in = wr_ptr_ff + AW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + AW'(pop);
   assign count_in  = count_ff + (AW+1)'(push.count) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < push.count) begin
            mem[wr_ptr_ff + AW'(k)] <= push.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `B64D_ASSERT_ALWAYS(a_no_overflow, clock, reset, count_ff <= (AW+1)'(DEPTH))
   `B64D_ASSERT_ALWAYS(a_push_fits, clock, reset, push.count == 2'd0 || room)
   `B64D_ASSERT_NEXT(a_pop_drains, clock, reset, pop && push.count == 2'd0,
      count_ff == $past(count_ff) - 1'b1)

endmodule

FILE: rtl/core/base64_decoder.sv
// ----------------------------------------------------------------------------
// Base64 decoder
// Streaming standard-alphabet Base64 decoder, one character per word in,
// one decoded byte or status word out.
// ----------------------------------------------------------------------------
//   channel   dir   word contents
//   req_bus   in    char_code[7:0], end_of_message
//   rsp_bus   out   data_byte[7:0], byte_valid, message_done, status[1:0]
//
// One character is taken every cycle while the result queue has room for
// three words; a quartet gives at most three bytes per four characters.
// A taken character is held in the input register until the queue has room;
// its results then pass through the quartet engine into the result queue.
// reset is synchronous and clears message state and the queue.
// A stalled rsp_bus fills the queue (DEPTH words, a power of two, at least
// four) until fewer than three words are free; the waiting character then
// holds req_bus.ready low.
// ----------------------------------------------------------------------------
module base64_decoder
   import b64d_pkg::*;
#(
   parameter int DEPTH = B64D_RSP_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_bus,
   b64d_rsp_if.source rsp_bus
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_eom_ff;

   logic       room;
   logic       step;
   logic       take;
   bundle_type bundle;

   // advance the held character when the queue can absorb its results
   assign step            = in_valid_ff && room;
   assign req_bus.ready   = !in_valid_ff || room;
   assign take            = req_bus.valid && req_bus.ready;
   assign in_valid_in     = take || (in_valid_ff && !room);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset; load only on a taken word
   always_ff @(posedge clock) begin
      if (take) begin
         in_char_ff <= req_bus.char_code;
         in_eom_ff  <= req_bus.end_of_message;
      end
   end

   b64d_quartet u_quartet (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .char_code      (in_char_ff),
      .end_of_message (in_eom_ff),
      .bundle         (bundle)
   );

   b64d_rsp_fifo #(
      .DEPTH (DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (bundle),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule
